/* rtl/cpwq_pkg.sv */
// Types and codes used by the coalescing page work queue core.
package cpwq_pkg;

  typedef enum logic [1:0] {
    OP_SIGNAL  = 2'd0,
    OP_COLLECT = 2'd1,
    OP_FINISH  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MK_IDLE   = 2'd0,
    MK_QUEUED = 2'd1,
    MK_DRAIN  = 2'd2,
    MK_DIRTY  = 2'd3
  } mark_e;

  typedef enum logic [3:0] {
    ACT_QUEUED    = 4'd0,
    ACT_DIRTIED   = 4'd1,
    ACT_UNCHANGED = 4'd2,
    ACT_DRAIN     = 4'd3,
    ACT_SKIPPED   = 4'd4,
    ACT_NOTHING   = 4'd5,
    ACT_IDLED     = 4'd6,
    ACT_REQUEUED  = 4'd7,
    ACT_IGNORED   = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_POP_RD,
    ST_POP_WB
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] page_index;
    logic [5:0] budget;
  } cpwq_in_t;

  typedef struct packed {
    logic [7:0] page_id;
    logic [3:0] action;
    logic [5:0] processed;
    logic [8:0] pending_total;
    logic       last;
  } cpwq_out_t;

endpackage

/* rtl/cpwq_ram.sv */
// Single-port-write, registered-read memory used for page marks and links.
module cpwq_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/coalescing_page_work_queue_core.sv */
// Coalescing page work queue: page marks and LIFO links kept in synchronous memories.
// Results: a signal or finish is strobed from the execute state, an empty collect from the
//   pop-read state, both through a result register. One item at a time, busy until done;
//   signal/finish read the mark, then modify and write back; a collect pops pages one by
//   one, each pop a read of mark and link memories, then a write-back of a queued mark.
// Reset: stack and carry heads go null, count to zero; then a clearing pass over every page
//   writes every mark idle, with busy held high. Results cannot be stalled by the receiver.
module coalescing_page_work_queue_core #(
  parameter int PAGES      = 256,
  parameter int MAX_BUDGET = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  cpwq_pkg::cpwq_in_t item_i,
  output logic               strobe_o,
  output cpwq_pkg::cpwq_out_t result_o
);

  import cpwq_pkg::*;

  // AW indexes a page, LW also holds the null link (value PAGES).
  localparam int AW = $clog2(PAGES);
  localparam int LW = $clog2(PAGES + 1);
  localparam int PW = $clog2(PAGES + 1);
  localparam int BW = $clog2(MAX_BUDGET + 1);
  localparam logic [LW-1:0] NIL      = LW'(PAGES);
  localparam logic [AW-1:0] LAST_PG  = AW'(PAGES - 1);

  state_e state_q, state_d;

  logic [1:0]    op_q, op_d;
  logic [7:0]    pg_q, pg_d;
  logic [BW-1:0] budget_q, budget_d;
  logic [BW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] stack_q, stack_d;
  logic [LW-1:0] carry_q, carry_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          strobe_q, strobe_d;
  cpwq_out_t     res_q, res_d;

  // memory ports
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic [1:0]    mark_wdata;
  logic [1:0]    mark_rdata;
  logic          link_we;
  logic [LW-1:0] link_rdata;
  logic [AW-1:0] rd_addr;

  // status used by next-state and datapath logic
  logic          lists_empty;
  logic          pop_last;
  logic [LW-1:0] link_next;
  logic [BW-1:0] cnt_inc;
  logic          pg_ok;
  logic [7:0]    budget_in;

  cpwq_ram #(
    .WIDTH(2),
    .DEPTH(PAGES),
    .AW   (AW)
  ) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (mark_we),
    .waddr_i(mark_waddr),
    .wdata_i(mark_wdata),
    .raddr_i(rd_addr),
    .rdata_o(mark_rdata)
  );

  cpwq_ram #(
    .WIDTH(LW),
    .DEPTH(PAGES),
    .AW   (AW)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(AW'(pg_q)),
    .wdata_i(stack_q),
    .raddr_i(rd_addr),
    .rdata_o(link_rdata)
  );

  // Status -----------------------------------------------------------------
  always_comb begin
    lists_empty = (carry_q == NIL) && (stack_q == NIL);
    // links are only read after being written; clamp keeps junk off the head
    link_next   = (link_rdata > NIL) ? NIL : link_rdata;
    cnt_inc     = cnt_q + BW'(1);
    // stack is already null here if this collect swapped it in
    pop_last    = (cnt_inc == budget_q) || ((link_next == NIL) && (stack_q == NIL));
    pg_ok       = (32'(pg_q) < 32'(PAGES));
    budget_in   = 8'(item_i.budget);
  end

  // Next state -------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_PG) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          state_d = (item_i.opcode == OP_COLLECT) ? ST_POP_RD : ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      ST_POP_RD: begin
        state_d = (lists_empty || (budget_q == '0)) ? ST_IDLE : ST_POP_WB;
      end
      ST_POP_WB: begin
        state_d = pop_last ? ST_IDLE : ST_POP_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs ---------------------------------------------------
  always_comb begin
    op_d       = op_q;
    pg_d       = pg_q;
    budget_d   = budget_q;
    cnt_d      = cnt_q;
    stack_d    = stack_q;
    carry_d    = carry_q;
    pend_d     = pend_q;
    clr_d      = clr_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    mark_we    = 1'b0;
    mark_waddr = AW'(pg_q);
    mark_wdata = MK_IDLE;
    link_we    = 1'b0;
    rd_addr    = AW'(pg_q);

    case (state_q)
      ST_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_q;
        mark_wdata = MK_IDLE;
        clr_d      = clr_q + AW'(1);
      end

      ST_IDLE: begin
        rd_addr = AW'(item_i.page_index);
        if (start) begin
          op_d     = item_i.opcode;
          pg_d     = item_i.page_index;
          budget_d = (32'(budget_in) > 32'(MAX_BUDGET)) ? BW'(MAX_BUDGET)
                                                        : BW'(item_i.budget);
          cnt_d    = '0;
        end
      end

      // mark of pg_q arrived: modify and write back
      ST_EXEC: begin
        res_d.page_id   = pg_q;
        res_d.processed = '0;
        res_d.last      = 1'b1;
        strobe_d        = 1'b1;
        case (op_q)
          OP_SIGNAL: begin
            res_d.action = ACT_UNCHANGED;
            if (pg_ok && (mark_rdata == MK_IDLE)) begin
              mark_we      = 1'b1;
              mark_wdata   = MK_QUEUED;
              link_we      = 1'b1;
              stack_d      = LW'(pg_q);
              pend_d       = pend_q + PW'(1);
              res_d.action = ACT_QUEUED;
            end else if (pg_ok && (mark_rdata == MK_DRAIN)) begin
              mark_we      = 1'b1;
              mark_wdata   = MK_DIRTY;
              res_d.action = ACT_DIRTIED;
            end
          end
          OP_FINISH: begin
            res_d.action = ACT_IGNORED;
            if (pg_ok && (mark_rdata == MK_DRAIN)) begin
              mark_we      = 1'b1;
              mark_wdata   = MK_IDLE;
              res_d.action = ACT_IDLED;
            end else if (pg_ok && (mark_rdata == MK_DIRTY)) begin
              mark_we      = 1'b1;
              mark_wdata   = MK_QUEUED;
              link_we      = 1'b1;
              stack_d      = LW'(pg_q);
              pend_d       = pend_q + PW'(1);
              res_d.action = ACT_REQUEUED;
            end
          end
          default: begin
            res_d.page_id = '0;
            res_d.action  = ACT_NOTHING;
          end
        endcase
        res_d.pending_total = 9'(pend_d);
      end

      // pick the head to pop; swap the stack in when the carry list is empty
      ST_POP_RD: begin
        if (lists_empty || (budget_q == '0)) begin
          res_d.page_id       = '0;
          res_d.action        = ACT_NOTHING;
          res_d.processed     = '0;
          res_d.pending_total = 9'(pend_q);
          res_d.last          = 1'b1;
          strobe_d            = 1'b1;
        end else if (carry_q == NIL) begin
          carry_d = stack_q;
          stack_d = NIL;
          rd_addr = AW'(stack_q);
        end else begin
          rd_addr = AW'(carry_q);
        end
      end

      // mark and link of the head arrived
      ST_POP_WB: begin
        carry_d    = link_next;
        pend_d     = (pend_q != '0) ? pend_q - PW'(1) : pend_q;
        cnt_d      = cnt_inc;
        mark_waddr = AW'(carry_q);
        if (mark_rdata == MK_QUEUED) begin
          mark_we      = 1'b1;
          mark_wdata   = MK_DRAIN;
          res_d.action = ACT_DRAIN;
        end else begin
          res_d.action = ACT_SKIPPED;
        end
        res_d.page_id       = 8'(carry_q);
        res_d.processed     = 6'(cnt_inc);
        res_d.pending_total = 9'(pend_d);
        res_d.last          = pop_last;
        strobe_d            = 1'b1;
      end

      default: ;
    endcase
  end

  // Registers --------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      stack_q  <= NIL;
      carry_q  <= NIL;
      pend_q   <= '0;
      clr_q    <= '0;
      strobe_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      stack_q  <= stack_d;
      carry_q  <= carry_d;
      pend_q   <= pend_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pg_q     <= pg_d;
    budget_q <= budget_d;
    res_q    <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = res_q;

  // Assertions -------------------------------------------------------------
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= 32'(PAGES))
    else $error("pending count exceeds page count");

  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == '0) == ((stack_q == NIL) && (carry_q == NIL)))
    else $error("pending count disagrees with list heads");

  a_collect_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !res_q.last) |-> ##2 strobe_q)
    else $error("collect stopped without a final item");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !strobe_q)
    else $error("result strobed during clearing pass");

endmodule
